>>> hdl/pua_pkg.sv
package pua_pkg;

    // Table geometry.
    localparam int NUM_DIRS    = 10;
    localparam int IDS_PER_DIR = 20;

    // Fixed field widths.
    localparam int ID_W   = 32;
    localparam int MASK_W = 32;
    localparam int IDX_W  = 5;
    localparam int STAT_W = 2;

    localparam int DIR_W   = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
    localparam int SLOT_W  = (IDS_PER_DIR > 1) ? $clog2(IDS_PER_DIR) : 1;
    localparam int SLOT_CW = $clog2(IDS_PER_DIR + 1);
    localparam int ADDR_W  = DIR_W + SLOT_W;

    localparam logic [IDX_W:0] DIR_LIMIT = (IDX_W + 1)'(NUM_DIRS);

    // Configuration registers.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_ON    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_APP_UID_START = CFG_IDX_W'(1);
    localparam logic [ID_W-1:0]      APP_UID_RESET     = ID_W'(10000);

    // Operation codes.
    localparam logic FUNC_CHECK  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_MASK  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_UID   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    // Per-directory bookkeeping seen by the sequencer.
    typedef struct packed {
        logic               enabled;
        logic [SLOT_W-1:0]  fp;
        logic [SLOT_CW-1:0] cnt;
    } dir_info_t;

    // Update request from the sequencer to the directory state.
    typedef struct packed {
        logic             en_we;
        logic             en_val;
        logic             fp_adv;
        logic [DIR_W-1:0] dir;
    } dir_upd_t;

    typedef struct packed {
        logic              bypass;
        logic [STAT_W-1:0] status;
    } result_t;

    // Position of the highest set bit; zero for a zero mask.
    function automatic logic [IDX_W-1:0] high_bit_index(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> hdl/per_dir_uid_allowlist.sv
// Channel   Direction  Beat contents
// s_*       in         tdata: dir_mask[31:0], user_id[63:32]; tuser: func
// m_*       out        tdata: bypass[0], status[2:1], zero[7:3]
// cfg_*     in         cfg_index selects the register, cfg_data is the value
//
// One item is in flight at a time. Each item passes through capture,
// decode, a scan of up to IDS_PER_DIR ring slots through the id memory's
// single read port (one slot per cycle, with registered read data), and a
// final step that loads the result and writes back any new id. Items settled
// without a scan (early check exits, enable writes, rejected updates) go
// straight from decode to the final step.
// Reset clears the enable bits, fill pointers and wrap flags at once; ring
// slots beyond the valid count read as empty, so the id memory needs no
// clearing pass. A result waiting on m_tready holds the block in its final
// step; the output register frees the next item to be accepted as soon as
// that result is loaded.
module per_dir_uid_allowlist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,  // dir_mask, user_id
    input  logic                              s_tuser,  // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // bypass, status, pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pua_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pua_pkg::ID_W-1:0]          cfg_data
);
    import pua_pkg::*;

    logic            protect_on_reg;
    logic [ID_W-1:0] app_uid_reg;
    logic            m_valid_reg;
    result_t         m_res_reg;

    logic              out_free;
    logic              res_load;
    result_t           res;
    logic [DIR_W-1:0]  info_dir;
    dir_info_t         info;
    dir_upd_t          upd;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_W-1:0]   ram_rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ID_W-1:0]   ram_wdata;

    // Configuration writes are taken every cycle; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protect_on_reg <= 1'b1;
            app_uid_reg    <= APP_UID_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROTECT_ON:    protect_on_reg <= cfg_data[0];
                CFG_APP_UID_START: app_uid_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Output register: a new result may load when the slot is empty or the
    // current beat leaves in the same cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_res_reg.status, m_res_reg.bypass};

    pua_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .protect_on    (protect_on_reg),
        .app_uid_start (app_uid_reg),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res),
        .info_dir      (info_dir),
        .info          (info),
        .upd           (upd),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    pua_dir_state u_dir_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .info_dir (info_dir),
        .info     (info),
        .upd      (upd)
    );

    // Ring slots addressed as {directory, slot}.
    pua_id_ram #(
        .AW (ADDR_W),
        .DW (ID_W)
    ) u_id_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> hdl/pua_id_ram.sv
module pua_id_ram #(
    parameter int AW = 9,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [1 << AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/pua_dir_state.sv
module pua_dir_state (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [pua_pkg::DIR_W-1:0] info_dir,
    output pua_pkg::dir_info_t    info,
    input  pua_pkg::dir_upd_t     upd
);
    import pua_pkg::*;

    logic              en_reg   [NUM_DIRS];
    logic [SLOT_W-1:0] fp_reg   [NUM_DIRS];
    logic              wrap_reg [NUM_DIRS];
    logic [SLOT_W-1:0] fp_next;
    logic              wrap_evt;

    // A ring that has wrapped holds a full set of ids; otherwise the fill
    // pointer is the number of slots written since reset.
    always_comb
    begin
        info.enabled = en_reg[info_dir];
        info.fp      = fp_reg[info_dir];
        info.cnt     = wrap_reg[info_dir] ? SLOT_CW'(IDS_PER_DIR)
                                          : SLOT_CW'(fp_reg[info_dir]);
    end

    assign wrap_evt = (fp_reg[upd.dir] == SLOT_W'(IDS_PER_DIR - 1));
    assign fp_next  = wrap_evt ? '0 : fp_reg[upd.dir] + SLOT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIRS; d++)
            begin
                en_reg[d]   <= 1'b0;
                fp_reg[d]   <= '0;
                wrap_reg[d] <= 1'b0;
            end
        end
        else
        begin
            if (upd.en_we)
            begin
                en_reg[upd.dir] <= upd.en_val;
            end
            if (upd.fp_adv)
            begin
                fp_reg[upd.dir] <= fp_next;
                if (wrap_evt)
                begin
                    wrap_reg[upd.dir] <= 1'b1;
                end
            end
        end
    end

endmodule

>>> hdl/pua_seq.sv
module pua_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,
    input  logic                       s_tuser,
    input  logic                       protect_on,
    input  logic [pua_pkg::ID_W-1:0]   app_uid_start,
    input  logic                       out_free,
    output logic                       res_load,
    output pua_pkg::result_t           res,
    output logic [pua_pkg::DIR_W-1:0]  info_dir,
    input  pua_pkg::dir_info_t         info,
    output pua_pkg::dir_upd_t          upd,
    output logic                       ram_re,
    output logic [pua_pkg::ADDR_W-1:0] ram_raddr,
    input  logic [pua_pkg::ID_W-1:0]   ram_rdata,
    output logic                       ram_we,
    output logic [pua_pkg::ADDR_W-1:0] ram_waddr,
    output logic [pua_pkg::ID_W-1:0]   ram_wdata
);
    import pua_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               func_reg, func_next;
    logic [ID_W-1:0]    uid_reg, uid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               mzero_reg, mzero_next;
    logic               pow2_reg, pow2_next;
    logic [SLOT_CW-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_CW-1:0] cmp_slot_reg, cmp_slot_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               add_reg, add_next;
    logic               en_we_reg, en_we_next;
    result_t            res_reg, res_next;

    logic [MASK_W-1:0]  in_mask;
    logic [ID_W-1:0]    in_uid;
    logic               in_range;
    logic               uid_low;
    logic               uid_is_flag;
    logic [ID_W-1:0]    eff_id;
    logic               last_slot;
    logic               finish;

    assign in_mask     = s_tdata[MASK_W-1:0];
    assign in_uid      = s_tdata[MASK_W +: ID_W];
    assign in_range    = ({1'b0, idx_reg} < DIR_LIMIT);
    assign uid_low     = (uid_reg < app_uid_start);
    assign uid_is_flag = (uid_reg[ID_W-1:1] == '0);
    assign info_dir    = idx_reg[DIR_W-1:0];

    // Slots at or beyond the valid count read as empty.
    assign eff_id    = (cmp_slot_reg < info.cnt) ? ram_rdata : '0;
    assign last_slot = (cmp_slot_reg == SLOT_CW'(IDS_PER_DIR - 1));

    assign s_tready  = (state_reg == S_IDLE);
    assign finish    = (state_reg == S_FINISH) && out_free;
    assign res_load  = finish;
    assign res       = res_reg;

    assign ram_re    = (state_reg == S_SCAN) && (rd_slot_reg < SLOT_CW'(IDS_PER_DIR));
    assign ram_raddr = {info_dir, rd_slot_reg[SLOT_W-1:0]};
    assign ram_we    = finish && add_reg;
    assign ram_waddr = {info_dir, info.fp};
    assign ram_wdata = uid_reg;

    always_comb
    begin
        upd.en_we  = finish && en_we_reg;
        upd.en_val = uid_reg[0];
        upd.fp_adv = finish && add_reg;
        upd.dir    = info_dir;
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        uid_next      = uid_reg;
        idx_next      = idx_reg;
        mzero_next    = mzero_reg;
        pow2_next     = pow2_reg;
        rd_slot_next  = rd_slot_reg;
        cmp_slot_next = cmp_slot_reg;
        cmp_vld_next  = 1'b0;
        add_next      = add_reg;
        en_we_next    = en_we_reg;
        res_next      = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    uid_next   = in_uid;
                    idx_next   = high_bit_index(in_mask);
                    mzero_next = (in_mask == '0);
                    pow2_next  = ((in_mask & (in_mask - MASK_W'(1))) == '0);
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                add_next     = 1'b0;
                en_we_next   = 1'b0;
                res_next     = '{bypass: 1'b0, status: ST_OK};
                rd_slot_next = '0;
                state_next   = S_FINISH;
                if (func_reg == FUNC_CHECK)
                begin
                    if (!protect_on || uid_low || mzero_reg || !in_range || !info.enabled)
                    begin
                        res_next.bypass = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (mzero_reg || !pow2_reg)
                    begin
                        res_next.status = ST_BAD_MASK;
                    end
                    else if (uid_low && !uid_is_flag)
                    begin
                        res_next.status = ST_BAD_UID;
                    end
                    else if (!in_range)
                    begin
                        res_next.status = ST_BAD_INDEX;
                    end
                    else if (uid_is_flag)
                    begin
                        en_we_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads are issued back to back; each compare sees the word
                // fetched in the cycle before.
                if (ram_re)
                begin
                    rd_slot_next  = rd_slot_reg + SLOT_CW'(1);
                    cmp_slot_next = rd_slot_reg;
                    cmp_vld_next  = 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (func_reg == FUNC_CHECK)
                    begin
                        if (eff_id == uid_reg)
                        begin
                            res_next.bypass = 1'b1;
                            state_next      = S_FINISH;
                        end
                        else if (eff_id == '0 || last_slot)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    else
                    begin
                        if (eff_id == uid_reg)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (eff_id == '0 || last_slot)
                        begin
                            add_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            add_reg     <= 1'b0;
            en_we_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            add_reg     <= add_next;
            en_we_reg   <= en_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        uid_reg      <= uid_next;
        idx_reg      <= idx_next;
        mzero_reg    <= mzero_next;
        pow2_reg     <= pow2_next;
        rd_slot_reg  <= rd_slot_next;
        cmp_slot_reg <= cmp_slot_next;
        res_reg      <= res_next;
    end

endmodule

>>> hdl/pua_chk.sv
module pua_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [7:0]                    m_tdata
);

    // One item at a time: an accepted beat closes the input side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A result carries either a bypass grant or an update status, never both.
    a_bypass_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[2:1] != 2'd0)))
        else $error("bypass set together with a nonzero status");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'd0))
        else $error("padding bits of the result beat are not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // A reset edge leaves the output empty for the following cycle.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result beat shown right after reset");

endmodule

bind per_dir_uid_allowlist pua_chk u_pua_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pua_pkg::*;

    // Cycles without any accepted beat on any channel before the run is abandoned.
    // The limit sits well above the slowest item plus the random gaps on each
    // side and the long receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_LEN       = 300;
    localparam int SETTLE_CYCLES  = 30;
    localparam int MAX_REPORTS    = 10;

    // The register index is two bits wide, so two indexes decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = CFG_IDX_W'(3);

    // One request to the allowlist table, as the sender queues it.
    typedef struct packed {
        logic              func;
        logic [MASK_W-1:0] mask;
        logic [ID_W-1:0]   uid;
    } request_t;

    // One answer from the table.
    typedef struct packed {
        logic              bypass;
        logic [STAT_W-1:0] status;
    } answer_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ID_W-1:0]      cfg_data  = '0;

    per_dir_uid_allowlist DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered, and answers predicted for accepted requests.
    request_t pending_requests[$];
    answer_t  predicted_answers[$];

    // Shadow copy of the table and its registers, kept in step with the block.
    logic              prot_on   = 1'b1;
    logic [ID_W-1:0]   app_start = APP_UID_RESET;
    logic [ID_W-1:0]   ring [NUM_DIRS][IDS_PER_DIR];
    logic [NUM_DIRS-1:0] dir_en  = '0;
    int                ring_ptr [NUM_DIRS];

    // Handshake events seen at the last rising edge.
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    logic cfg_fire = 1'b0;

    int   mismatches = 0;
    int   idle_cycles = 0;

    // Flow control knobs set by the sequence. When no_idle is set, neither
    // side inserts gaps, so that the block runs at its own pace.
    logic no_idle     = 1'b0;
    int   hold_asked  = 0;
    int   hold_served = 0;
    int   hold_left   = 0;
    int   send_gap    = 0;
    int   recv_gap    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            ring_ptr[d] = 0;
            for (int s = 0; s < IDS_PER_DIR; s++)
            begin
                ring[d][s] = '0;
            end
        end
    end

    // Position of the most significant set bit of a directory mask.
    function automatic logic [IDX_W-1:0] top_bit(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (m[i])
            begin
                pos = IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // Computes the answer to one accepted request and applies any table change.
    function automatic answer_t apply_request(input request_t rq);
        answer_t          a;
        logic [IDX_W-1:0] d;
        logic             hit;
        a.bypass = 1'b0;
        a.status = ST_OK;
        d = top_bit(rq.mask);
        if (rq.func == FUNC_CHECK)
        begin
            // Any of the early exits lets the caller through without a scan.
            if (!prot_on || rq.uid < app_start || rq.mask == '0)
            begin
                a.bypass = 1'b1;
            end
            else if (d >= NUM_DIRS)
            begin
                a.bypass = 1'b1;
            end
            else if (!dir_en[d])
            begin
                a.bypass = 1'b1;
            end
            else
            begin
                // The compare comes ahead of the empty test, so an id of zero
                // matches the first empty slot.
                for (int i = 0; i < IDS_PER_DIR; i++)
                begin
                    if (ring[d][i] == rq.uid)
                    begin
                        a.bypass = 1'b1;
                        break;
                    end
                    if (ring[d][i] == '0)
                    begin
                        break;
                    end
                end
            end
        end
        else
        begin
            if (rq.mask == '0 || (rq.mask & (rq.mask - 1)) != '0)
            begin
                a.status = ST_BAD_MASK;
            end
            else if (rq.uid < app_start && rq.uid > 1)
            begin
                a.status = ST_BAD_UID;
            end
            else if (d >= NUM_DIRS)
            begin
                a.status = ST_BAD_INDEX;
            end
            else if (rq.uid <= 1)
            begin
                dir_en[d] = rq.uid[0];
            end
            else
            begin
                hit = 1'b0;
                for (int i = 0; i < IDS_PER_DIR; i++)
                begin
                    if (ring[d][i] == '0)
                    begin
                        break;
                    end
                    if (ring[d][i] == rq.uid)
                    begin
                        hit = 1'b1;
                        break;
                    end
                end
                // A new id goes in at the fill pointer, which wraps so that a
                // full ring loses its oldest entry.
                if (!hit)
                begin
                    ring[d][ring_ptr[d]] = rq.uid;
                    ring_ptr[d] = (ring_ptr[d] == IDS_PER_DIR - 1) ? 0 : ring_ptr[d] + 1;
                end
            end
        end
        return a;
    endfunction

    // An id from a small pool just at or above the app threshold, so that ids
    // repeat, get listed, and overflow the ring of the busier directories.
    function automatic logic [ID_W-1:0] pool_uid();
        int unsigned k;
        k = $urandom_range(0, 39);
        if (app_start <= 32'hFFFF_FF00)
        begin
            return app_start + k;
        end
        return 32'hFFFF_FFFF - k;
    endfunction

    // A random request. Most are well formed and aimed at the low directories;
    // the rest are out-of-range indexes, multi-bit masks, zero masks and raw noise.
    function automatic request_t random_request();
        request_t    rq;
        int unsigned roll;
        int unsigned d;
        rq.func = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        d = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) : $urandom_range(0, NUM_DIRS - 1);
        if (roll < 72)
        begin
            rq.mask = 32'h1 << d;
        end
        else if (roll < 82)
        begin
            rq.mask = 32'h1 << $urandom_range(NUM_DIRS, MASK_W - 1);
        end
        else if (roll < 92)
        begin
            rq.mask = (32'h1 << d) | ($urandom & ((32'h1 << d) - 1)) | 32'h1;
            if (d == 0)
            begin
                rq.mask = 32'h1 << d;
            end
        end
        else if (roll < 95)
        begin
            rq.mask = '0;
        end
        else
        begin
            rq.mask = $urandom;
        end

        roll = $urandom_range(0, 99);
        if (rq.func == FUNC_UPDATE && roll < 15)
        begin
            // Enable writes lean towards switching a directory on.
            rq.uid = ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0;
        end
        else if (roll < 75)
        begin
            rq.uid = pool_uid();
        end
        else if (roll < 88 && app_start != '0)
        begin
            rq.uid = $urandom_range(0, app_start - 1);
        end
        else if (roll < 92)
        begin
            rq.uid = '0;
        end
        else
        begin
            rq.uid = $urandom;
        end
        return rq;
    endfunction

    task automatic queue_request(input logic func, input logic [MASK_W-1:0] mask,
                                 input logic [ID_W-1:0] uid);
        request_t rq;
        rq.func = func;
        rq.mask = mask;
        rq.uid  = uid;
        pending_requests.push_back(rq);
    endtask

    task automatic queue_random(input int count);
        repeat (count)
        begin
            pending_requests.push_back(random_request());
        end
    endtask

    // Waits until every queued request has been offered and answered, then lets
    // the block settle before anything else changes.
    task automatic drain();
        while (pending_requests.size() != 0 || s_tvalid || predicted_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write through the configuration channel; the shadow copy
    // follows once the beat is accepted.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == CFG_PROTECT_ON)
        begin
            prot_on = val[0];
        end
        else if (idx == CFG_APP_UID_START)
        begin
            app_start = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sender. A request stays on the bus until it is taken; after each accepted
    // beat a new gap is drawn before the next one is offered.
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n && !(s_tvalid && !in_fire))
        begin
            if (in_fire)
            begin
                send_gap = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                rq = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {rq.uid, rq.mask};
                s_tuser  <= rq.func;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. It stalls for a random number of cycles after each answer, and
    // on request holds off for a long stretch so that the block backs up.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = HOLD_LEN - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                recv_gap = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= rst_n;
            end
        end
    end

    // Monitor. Values read here are those present just ahead of the edge.
    // The answer is checked ahead of the new prediction so that a request
    // taken on the same edge never pairs with an older answer.
    always @(posedge clk)
    begin
        answer_t want;
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        cfg_fire = rst_n && cfg_valid && cfg_ready;

        if (out_fire)
        begin
            if (predicted_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected answer beat: tdata=%h", m_tdata);
                end
            end
            else
            begin
                want = predicted_answers.pop_front();
                if (m_tdata[0] !== want.bypass || m_tdata[2:1] !== want.status
                    || m_tdata[7:3] !== 5'b0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("answer mismatch: bypass exp %b got %b, status exp %0d got %0d, pad %b",
                                 want.bypass, m_tdata[0], want.status, m_tdata[2:1], m_tdata[7:3]);
                    end
                end
            end
        end

        if (in_fire)
        begin
            predicted_answers.push_back(apply_request({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
        end

        // Watchdog on forward progress of any channel.
        if (in_fire || out_fire || cfg_fire || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d answers outstanding",
                         predicted_answers.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: protection on, threshold at its reset value.
        queue_request(FUNC_CHECK,  32'h1,         32'd20000);  // directory still disabled
        queue_request(FUNC_UPDATE, 32'h1,         32'd1);      // enable directory 0
        queue_request(FUNC_CHECK,  32'h1,         32'd20000);  // empty ring, no match
        queue_request(FUNC_UPDATE, 32'h1,         32'd20000);  // list the id
        queue_request(FUNC_CHECK,  32'h1,         32'd20000);  // now listed
        queue_request(FUNC_UPDATE, 32'h1,         32'd20000);  // duplicate add is a no-op
        queue_request(FUNC_CHECK,  32'h1,         32'd20001);  // not listed
        queue_request(FUNC_CHECK,  32'h1,         32'd9999);   // just below the threshold
        queue_request(FUNC_CHECK,  32'h1,         32'd10000);  // exactly at the threshold
        queue_request(FUNC_CHECK,  32'h0,         32'd20001);  // empty mask
        queue_request(FUNC_CHECK,  32'h8000_0000, 32'hFFFF_FFFF);  // index out of range
        queue_request(FUNC_CHECK,  32'h0000_0003, 32'd20001);  // two bits, directory 1 off
        queue_request(FUNC_UPDATE, 32'h0,         32'd20000);  // empty mask is rejected
        queue_request(FUNC_UPDATE, 32'h3,         32'd5000);   // mask test wins over id test
        queue_request(FUNC_UPDATE, 32'h1,         32'd5000);   // app id below the threshold
        queue_request(FUNC_UPDATE, 32'h400,       32'd20000);  // directory 10 does not exist
        queue_request(FUNC_UPDATE, 32'h8000_0000, 32'd0);      // enable write out of range
        queue_request(FUNC_UPDATE, 32'h200,       32'd1);      // enable the last directory
        queue_request(FUNC_UPDATE, 32'h200,       32'hFFFF_FFFF);
        queue_request(FUNC_CHECK,  32'h0000_03FF, 32'hFFFF_FFFF);  // highest bit selects dir 9
        queue_request(FUNC_CHECK,  32'h0000_03FF, 32'hFFFF_FFFE);
        queue_request(FUNC_UPDATE, 32'h1,         32'd0);      // disable directory 0
        queue_request(FUNC_CHECK,  32'h1,         32'd20001);
        queue_request(FUNC_UPDATE, 32'h1,         32'd1);
        drain();

        // Random traffic with a long receiver stall at the start.
        hold_asked++;
        queue_random(80);
        drain();

        // Threshold at zero: a check for id zero can reach the scan and then
        // matches the first empty slot.
        write_reg(CFG_APP_UID_START, 32'd0);
        queue_request(FUNC_UPDATE, 32'h10, 32'd1);
        queue_request(FUNC_CHECK,  32'h10, 32'd0);
        queue_request(FUNC_UPDATE, 32'h10, 32'd5);
        queue_request(FUNC_CHECK,  32'h10, 32'd0);
        queue_request(FUNC_CHECK,  32'h10, 32'd6);
        queue_random(60);
        drain();

        // Protection off, back to back on both sides.
        write_reg(CFG_PROTECT_ON, 32'd0);
        no_idle = 1'b1;
        queue_random(60);
        drain();
        no_idle = 1'b0;

        // Writes to unused indexes must change nothing; then the highest threshold.
        write_reg(CFG_UNUSED_A, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_B, 32'h0000_0000);
        write_reg(CFG_PROTECT_ON, 32'hFFFF_FFFF);
        write_reg(CFG_APP_UID_START, 32'hFFFF_FFFF);
        queue_random(80);
        drain();

        // A random threshold, first with gaps, then without.
        write_reg(CFG_APP_UID_START, $urandom);
        hold_asked++;
        queue_random(80);
        drain();
        no_idle = 1'b1;
        queue_random(60);
        drain();
        no_idle = 1'b0;

        // Back to the reset threshold with one more long stall.
        write_reg(CFG_APP_UID_START, APP_UID_RESET);
        hold_asked++;
        queue_random(60);
        drain();

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
